>>> src/edge_to_vertex_scatter_add_unit_assert.svh
// Assertion macros for the scatter-add unit and its checker.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef EDGE_TO_VERTEX_SCATTER_ADD_UNIT_ASSERT_SVH
`define EDGE_TO_VERTEX_SCATTER_ADD_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define E2V_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define E2V_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/e2v_pkg.sv
// Shared types and constants of the edge-to-vertex scatter-add unit.
// Depends on nothing; used by every module of the block.
package e2v_pkg;

  localparam int VALUE_W    = 32;
  localparam int MODE_W     = 2;
  localparam int VERTEX_W   = 10;
  localparam int LANE_W     = 6;
  localparam int STATUS_W   = 2;
  localparam int FCNT_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Command codes on in_mode; the spare code behaves as a read.
  localparam logic [MODE_W-1:0] MODE_ACC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGN = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AGG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FCNT = 2'd1;

  localparam logic [FCNT_W-1:0] FCNT_RESET = 7'd64;

  localparam logic signed [VALUE_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_READ,
    OP_LOAD,
    OP_IGN
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
  } item_ctl_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

endpackage

>>> src/edge_to_vertex_scatter_add_unit.sv
// Top level of the edge-to-vertex scatter-add unit.
// Depends on e2v_pkg, e2v_front, e2v_queue and e2v_back.
//
//  channel   handshake            word
//  -------   ------------------   ---------------------------------------------
//  in        start / busy         in_mode, in_row_vertex, in_edge_target,
//                                 in_lane, in_value
//  out       out_valid (strobe)   out_entry_value, out_status
//  cfg       cfg_we               cfg_index, cfg_wdata
//
// A word is taken when start is high and busy is low. Each word yields one
// result word, shown for one cycle under out_valid. With the store's single
// read-modify-write port, the back end pops a word only when idle, then writes
// the entry and registers the result in its execute state before the next pop.
// After reset the store is swept to zero, one entry a cycle, over all
// MAX_VERTICES * MAX_FEATURES entries; busy stays high throughout, while
// configuration writes are still taken.
// The receiver cannot stall; a two-word queue lets the front end keep
// accepting while the back end is occupied, and busy rises when it fills.
module edge_to_vertex_scatter_add_unit #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_FEATURES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [e2v_pkg::MODE_W-1:0]         in_mode,
  input  logic [e2v_pkg::VERTEX_W-1:0]       in_row_vertex,
  input  logic [e2v_pkg::VERTEX_W-1:0]       in_edge_target,
  input  logic [e2v_pkg::LANE_W-1:0]         in_lane,
  input  logic signed [e2v_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  output logic signed [e2v_pkg::VALUE_W-1:0] out_entry_value,
  output logic [e2v_pkg::STATUS_W-1:0]       out_status,
  input  logic                               cfg_we,
  input  logic [e2v_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [e2v_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import e2v_pkg::*;

  // The store holds one entry per vertex and feature lane, vertex-major.
  localparam int DEPTH  = MAX_VERTICES * MAX_FEATURES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int Q_W    = ADDR_W + $bits(item_ctl_t);

  logic              push;
  item_ctl_t         push_ctl;
  logic [ADDR_W-1:0] push_addr;
  logic              q_pop;
  logic              q_empty;
  logic              q_full;
  logic [Q_W-1:0]    q_data;
  item_ctl_t         q_ctl;
  logic [ADDR_W-1:0] q_addr;
  logic              clearing;

  // The front end owns the configuration registers and turns each command
  // word into an operation code and a flat store address.
  e2v_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_FEATURES (MAX_FEATURES),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_row_vertex  (in_row_vertex),
    .in_edge_target (in_edge_target),
    .in_lane        (in_lane),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .q_full         (q_full),
    .clearing       (clearing),
    .push           (push),
    .push_ctl       (push_ctl),
    .push_addr      (push_addr)
  );

  e2v_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_addr, push_ctl}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign q_addr = q_data[Q_W-1 -: ADDR_W];
  assign q_ctl  = q_data[$bits(item_ctl_t)-1:0];

  // The back end handles one word at a time, so consecutive hits on the
  // same entry always see the previous write.
  e2v_back #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_ctl           (q_ctl),
    .q_addr          (q_addr),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_entry_value (out_entry_value),
    .out_status      (out_status)
  );

endmodule

>>> src/e2v_front.sv
// Front end: configuration registers, command acceptance and classification.
// Depends on e2v_pkg; feeds e2v_queue.
module e2v_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_FEATURES = 64,
  parameter int ADDR_W       = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [e2v_pkg::MODE_W-1:0]        in_mode,
  input  logic [e2v_pkg::VERTEX_W-1:0]      in_row_vertex,
  input  logic [e2v_pkg::VERTEX_W-1:0]      in_edge_target,
  input  logic [e2v_pkg::LANE_W-1:0]        in_lane,
  input  logic signed [e2v_pkg::VALUE_W-1:0] in_value,
  input  logic                              cfg_we,
  input  logic [e2v_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [e2v_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              q_full,
  input  logic                              clearing,
  output logic                              push,
  output e2v_pkg::item_ctl_t                push_ctl,
  output logic [ADDR_W-1:0]                 push_addr
);
  import e2v_pkg::*;

  logic              agg_r;
  logic [FCNT_W-1:0] fcnt_r;
  logic [VERTEX_W-1:0] vtx;
  logic [31:0]       addr_full;
  logic              ignore;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agg_r  <= 1'b0;
      fcnt_r <= FCNT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_AGG) begin
        agg_r <= cfg_wdata[0];
      end else if (cfg_index == CFG_FCNT) begin
        fcnt_r <= cfg_wdata;
      end
    end
  end

  assign busy = q_full || clearing;
  assign push = start && !busy;

  always_comb begin
    if (in_mode == MODE_ACC) begin
      vtx = agg_r ? in_row_vertex : in_edge_target;
    end else begin
      vtx = in_row_vertex;
    end
    ignore = ({1'b0, in_lane} >= fcnt_r) ||
             (32'(in_lane) >= 32'(MAX_FEATURES)) ||
             (32'(vtx) >= 32'(MAX_VERTICES));
    addr_full = 32'(vtx) * 32'(MAX_FEATURES) + 32'(in_lane);
    push_addr = addr_full[ADDR_W-1:0];
    push_ctl.value = in_value;
    if (ignore) begin
      push_ctl.op = OP_IGN;
    end else if (in_mode == MODE_ACC) begin
      push_ctl.op = OP_ACC;
    end else if (in_mode == MODE_LOAD) begin
      push_ctl.op = OP_LOAD;
    end else begin
      push_ctl.op = OP_READ;
    end
  end

endmodule

>>> src/e2v_queue.sv
// Two-entry queue between the front end and the store back end.
// Depends on e2v_pkg only for house conventions; width set by its user.
module e2v_queue #(
  parameter int WIDTH = 50
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);
  import e2v_pkg::*;

  logic [WIDTH-1:0] entries_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign empty    = (count_r == 2'd0);
  assign full     = (count_r == 2'd2);
  assign pop_data = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop && !empty) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/e2v_back.sv
// Back end: the accumulator store, its clearing sweep and the
// read-modify-write sequencer with saturating add. Depends on e2v_pkg.
module e2v_back #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  e2v_pkg::item_ctl_t                 q_ctl,
  input  logic [ADDR_W-1:0]                  q_addr,
  output logic                               q_pop,
  output logic                               clearing,
  output logic                               out_valid,
  output logic signed [e2v_pkg::VALUE_W-1:0] out_entry_value,
  output logic [e2v_pkg::STATUS_W-1:0]       out_status
);
  import e2v_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  bk_state_t           state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r;
  op_t                 op_r;
  logic [ADDR_W-1:0]   addr_r;
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] rd_data_r;
  logic                out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [VALUE_W-1:0]  wr_data;
  logic signed [VALUE_W:0] sum;
  logic signed [VALUE_W-1:0] sum_sat;
  logic                sat;
  logic signed [VALUE_W-1:0] res_value;
  logic [STATUS_W-1:0] res_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    sum = {rd_data_r[VALUE_W-1], rd_data_r} + {value_r[VALUE_W-1], value_r};
    sat = (sum[VALUE_W] != sum[VALUE_W-1]);
    if (!sat) begin
      sum_sat = sum[VALUE_W-1:0];
    end else if (sum[VALUE_W]) begin
      sum_sat = SAT_MIN;
    end else begin
      sum_sat = SAT_MAX;
    end

    unique case (op_r)
      OP_ACC: begin
        res_value  = sum_sat;
        res_status = sat ? ST_SAT : ST_OK;
      end
      OP_LOAD: begin
        res_value  = value_r;
        res_status = ST_OK;
      end
      OP_READ: begin
        res_value  = rd_data_r;
        res_status = ST_OK;
      end
      default: begin
        res_value  = '0;
        res_status = ST_IGN;
      end
    endcase

    state_nxt = state_r;
    q_pop     = 1'b0;
    clearing  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = addr_r;
    wr_data   = res_value;
    unique case (state_r)
      BK_CLEAR: begin
        clearing = 1'b1;
        wr_en    = 1'b1;
        wr_addr  = clr_cnt_r;
        wr_data  = '0;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        wr_en     = (op_r == OP_ACC) || (op_r == OP_LOAD);
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == BK_EXEC);
      if (state_r == BK_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // Item and result words need no reset: they are qualified by the state.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r    <= q_ctl.op;
      addr_r  <= q_addr;
      value_r <= q_ctl.value;
    end
    if (state_r == BK_EXEC) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_value = out_value_r;
  assign out_status      = out_status_r;

endmodule

>>> src/e2v_checker.sv
// Port-level checks of the scatter-add unit, bound to its top level.
// Depends on e2v_pkg and edge_to_vertex_scatter_add_unit_assert.svh.
module e2v_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               busy,
  input logic                               out_valid,
  input logic signed [e2v_pkg::VALUE_W-1:0] out_entry_value,
  input logic [e2v_pkg::STATUS_W-1:0]       out_status
);
  import e2v_pkg::*;

`include "edge_to_vertex_scatter_add_unit_assert.svh"

  // Leaving reset starts the clearing sweep, so the unit must look busy.
  `E2V_ASSERT_ALWAYS(a_busy_after_reset, !rst_n |=> busy, "busy low right after reset")

  `E2V_ASSERT_ALWAYS(a_no_strobe_after_reset, !rst_n |=> !out_valid, "result strobe after reset")

  // The back end goes back to idle after every word, so strobes never touch.
  `E2V_ASSERT(a_strobe_gap, out_valid |=> !out_valid, "back-to-back result strobes")

  `E2V_ASSERT(a_ignored_zero, (out_valid && out_status == ST_IGN) |-> out_entry_value == '0, "ignored word returns non-zero value")

  `E2V_ASSERT(a_sat_limit, (out_valid && out_status == ST_SAT) |-> (out_entry_value == SAT_MAX || out_entry_value == SAT_MIN), "saturated result not at a limit")

endmodule

bind edge_to_vertex_scatter_add_unit e2v_checker u_e2v_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_entry_value (out_entry_value),
  .out_status      (out_status)
);

>>> tb/e2v_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the edge-to-vertex scatter-add unit: keeps its own copy of the
// vertex store and registers, predicts every result word and compares it on arrival.
// Depends on e2v_pkg for widths, command, status and register codes.
module e2v_result_checker #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_FEATURES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [e2v_pkg::MODE_W-1:0]         in_mode,
  input  logic [e2v_pkg::VERTEX_W-1:0]       in_row_vertex,
  input  logic [e2v_pkg::VERTEX_W-1:0]       in_edge_target,
  input  logic [e2v_pkg::LANE_W-1:0]         in_lane,
  input  logic signed [e2v_pkg::VALUE_W-1:0] in_value,
  input  logic                               out_valid,
  input  logic signed [e2v_pkg::VALUE_W-1:0] out_entry_value,
  input  logic [e2v_pkg::STATUS_W-1:0]       out_status,
  input  logic                               cfg_we,
  input  logic [e2v_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [e2v_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                 fail_count,
  output int                                 outstanding
);
  import e2v_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] entry;
    logic [STATUS_W-1:0]       status;
  } entry_word_t;

  logic [VALUE_W-1:0] vertex_store [MAX_VERTICES*MAX_FEATURES];
  logic               by_row;
  logic [FCNT_W-1:0]  lanes_in_use;
  entry_word_t        expected_entries [$];

  // Applies one accepted word to the mirrored store and returns the word the unit
  // should give back for it.
  function automatic entry_word_t apply_edge_word(
    input logic [MODE_W-1:0]         mode,
    input logic [VERTEX_W-1:0]       row,
    input logic [VERTEX_W-1:0]       tgt,
    input logic [LANE_W-1:0]         lane,
    input logic signed [VALUE_W-1:0] value
  );
    int unsigned             vtx;
    int unsigned             addr;
    logic signed [VALUE_W:0] sum;
    entry_word_t             res;
    res.status = ST_OK;
    vtx = 32'((mode == MODE_ACC && !by_row) ? tgt : row);
    if (lane >= lanes_in_use || lane >= MAX_FEATURES || vtx >= MAX_VERTICES) begin
      res.entry  = '0;
      res.status = ST_IGN;
      return res;
    end
    addr = vtx * MAX_FEATURES + 32'(lane);
    case (mode)
      MODE_ACC: begin
        sum = $signed({vertex_store[addr][VALUE_W-1], vertex_store[addr]}) +
              $signed({value[VALUE_W-1], value});
        // The two top bits differ only when the true sum leaves the 32-bit range.
        if (sum[VALUE_W] != sum[VALUE_W-1]) begin
          vertex_store[addr] = sum[VALUE_W] ? SAT_MIN : SAT_MAX;
          res.status         = ST_SAT;
        end else begin
          vertex_store[addr] = sum[VALUE_W-1:0];
        end
      end
      MODE_LOAD: vertex_store[addr] = value;
      default: ;
    endcase
    res.entry = vertex_store[addr];
    return res;
  endfunction

  always @(posedge clk) begin
    entry_word_t want;
    if (!rst_n) begin
      foreach (vertex_store[i]) vertex_store[i] = '0;
      by_row       = 1'b0;
      lanes_in_use = FCNT_RESET;
      expected_entries.delete();
      outstanding  = 0;
      fail_count   = 0;
    end else begin
      if (out_valid) begin
        if (expected_entries.size() == 0) begin
          $display("%0t: result word with none expected: entry %h status %0d",
                   $time, out_entry_value, out_status);
          fail_count++;
        end else begin
          want = expected_entries.pop_front();
          outstanding--;
          if (out_entry_value !== want.entry) begin
            $display("%0t: entry_value mismatch: expected %h actual %h",
                     $time, want.entry, out_entry_value);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_status);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_AGG:  by_row = cfg_wdata[0];
          CFG_FCNT: lanes_in_use = cfg_wdata[FCNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_entries.push_back(apply_edge_word(in_mode, in_row_vertex, in_edge_target,
                                                   in_lane, in_value));
        outstanding++;
      end
    end
  end

endmodule

>>> tb/tb_edge_to_vertex_scatter_add_unit.sv
`timescale 1ns / 100ps
// Top of the testbench for the edge-to-vertex scatter-add unit: makes the stimulus
// and gives the verdict. Depends on e2v_pkg, the unit and e2v_result_checker.
module tb_edge_to_vertex_scatter_add_unit;
  import e2v_pkg::*;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_FEATURES = 64;

  // The limit covers the sweep of all MAX_VERTICES * MAX_FEATURES store entries
  // after reset and the word traffic after it, with ample headroom.
  localparam int CYCLE_LIMIT  = 400000;
  // Extra wait once every expected result word is back, before a register write.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_WORDS = 750;
  localparam int PHASES       = 6;

  // The spare command code and the register indexes with no register behind them.
  localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [MODE_W-1:0]           in_mode;
  logic [VERTEX_W-1:0]         in_row_vertex;
  logic [VERTEX_W-1:0]         in_edge_target;
  logic [LANE_W-1:0]           in_lane;
  logic signed [VALUE_W-1:0]   in_value;
  logic                        out_valid;
  logic signed [VALUE_W-1:0]   out_entry_value;
  logic [STATUS_W-1:0]         out_status;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_wdata;

  int                          fail_count;
  int                          outstanding;
  int unsigned                 cycle_count = 0;

  // When steady is set, words are offered back to back with no idle gaps.
  logic                        steady;
  // Our own note of the aggregation register, used only to aim repeated hits.
  logic                        cur_by_row;
  // The entry touched by the previous word, so that later words can hit it again.
  logic [VERTEX_W-1:0]         last_vtx;
  logic [LANE_W-1:0]           last_lane;

  edge_to_vertex_scatter_add_unit #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_FEATURES (MAX_FEATURES)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_row_vertex   (in_row_vertex),
    .in_edge_target  (in_edge_target),
    .in_lane         (in_lane),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_entry_value (out_entry_value),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  e2v_result_checker #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_result_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_row_vertex   (in_row_vertex),
    .in_edge_target  (in_edge_target),
    .in_lane         (in_lane),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_entry_value (out_entry_value),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a run that hangs, or loses result words, ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Now and then drops start for a random idle gap, unless the run is steady.
  task automatic idle_gap();
    if (!steady && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // Offers one word at the falling edge and holds it until a rising edge sees busy
  // low. It returns at the next falling edge with start still high, so that a
  // following word can be offered without a gap.
  task automatic send_word(
    input logic [MODE_W-1:0]         mode,
    input logic [VERTEX_W-1:0]       row,
    input logic [VERTEX_W-1:0]       tgt,
    input logic [LANE_W-1:0]         lane,
    input logic signed [VALUE_W-1:0] value
  );
    idle_gap();
    start          = 1'b1;
    in_mode        = mode;
    in_row_vertex  = row;
    in_edge_target = tgt;
    in_lane        = lane;
    in_value       = value;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    last_vtx  = (mode == MODE_ACC && !cur_by_row) ? tgt : row;
    last_lane = lane;
  endtask

  // Lowers start and waits until every expected result word has come back, then
  // a little longer so that the unit is truly idle before a register write.
  task automatic settle();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Values lean towards the Q16.16 limits so that sums saturate often.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      1:       return SAT_MAX - $urandom_range(0, 32'h00FF_FFFF);
      2:       return SAT_MIN + $urandom_range(0, 32'h00FF_FFFF);
      3:       return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
      default: return $urandom();
    endcase
  endfunction

  // Most words work on a handful of vertices so that accumulates, loads and reads
  // meet on the same entries; a fifth of them hit the previous entry again, which
  // checks that back-to-back hits see the previous write. The rest are noise over
  // the whole field range.
  task automatic send_random(input int lanes);
    logic [MODE_W-1:0]   mode;
    logic [VERTEX_W-1:0] row;
    logic [VERTEX_W-1:0] tgt;
    logic [LANE_W-1:0]   lane;
    int                  kind;
    kind = $urandom_range(0, 99);
    row  = VERTEX_W'($urandom_range(0, 7));
    tgt  = VERTEX_W'($urandom_range(0, 7));
    // One lane past the count is allowed so that ignored words keep turning up.
    lane = LANE_W'($urandom_range(0, (lanes > MAX_FEATURES - 1) ? MAX_FEATURES - 1 : lanes));
    if ($urandom_range(0, 4) == 0) begin
      row  = last_vtx;
      tgt  = last_vtx;
      lane = last_lane;
    end
    if (kind < 45) begin
      mode = MODE_ACC;
    end else if (kind < 60) begin
      mode = MODE_LOAD;
    end else if (kind < 82) begin
      mode = MODE_READ;
    end else if (kind < 87) begin
      mode = MODE_SPARE;
    end else begin
      mode = MODE_W'($urandom());
      row  = VERTEX_W'($urandom());
      tgt  = VERTEX_W'($urandom());
      lane = LANE_W'($urandom());
    end
    send_word(mode, row, tgt, lane, pick_value());
  endtask

  initial begin
    int lanes;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = MODE_ACC;
    in_row_vertex  = '0;
    in_edge_target = '0;
    in_lane        = '0;
    in_value       = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_AGG;
    cfg_wdata      = '0;
    steady         = 1'b1;
    cur_by_row     = 1'b0;
    last_vtx       = '0;
    last_lane      = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Register writes are taken while the store is being swept. Writes to the
    // spare indexes must leave both registers untouched.
    write_reg(CFG_SPARE_LO, 7'h7F);
    write_reg(CFG_SPARE_HI, 7'h7F);
    write_reg(CFG_AGG, 7'd0);
    write_reg(CFG_FCNT, FCNT_RESET);

    // Directed words, offered back to back. Aggregation by target, all lanes in use.
    send_word(MODE_READ, 0, 0, 0, 0);                      // freshly cleared entry
    send_word(MODE_LOAD, 1023, 0, 63, SAT_MAX);            // top vertex, top lane
    send_word(MODE_ACC, 0, 1023, 63, 1);                   // saturates upwards
    send_word(MODE_ACC, 0, 1023, 63, SAT_MIN);             // large step down, no clamp
    send_word(MODE_LOAD, 0, 0, 0, SAT_MIN);
    send_word(MODE_ACC, 512, 0, 0, -1);                    // saturates downwards
    send_word(MODE_ACC, 512, 0, 0, SAT_MIN);               // and again from the limit
    send_word(MODE_ACC, 0, 5, 3, 32'sh0001_8000);          // two hits on one entry
    send_word(MODE_ACC, 0, 5, 3, 32'sh0001_8000);
    send_word(MODE_READ, 5, 0, 3, 0);
    send_word(MODE_SPARE, 5, 9, 3, 32'hDEAD_BEEF);         // spare code reads only
    send_word(MODE_LOAD, 7, 0, 2, 32'sh1234_5678);
    send_word(MODE_ACC, 0, 7, 2, 32'hEDCB_A988);           // sums back to zero
    send_word(MODE_READ, 7, 0, 2, 0);

    // A single lane in use: every other lane is ignored, in every mode.
    settle();
    write_reg(CFG_FCNT, 7'd1);
    send_word(MODE_ACC, 0, 5, 1, 1);
    send_word(MODE_ACC, 0, 5, 0, 1);
    send_word(MODE_READ, 5, 0, 3, 0);
    send_word(MODE_LOAD, 5, 0, 63, SAT_MAX);

    // Aggregation by row vertex: the target index must have no effect.
    settle();
    write_reg(CFG_AGG, 7'd1);
    cur_by_row = 1'b1;
    send_word(MODE_ACC, 9, 100, 0, 32'sh0000_0100);
    send_word(MODE_READ, 9, 0, 0, 0);

    // A lane count of zero puts every lane out of range.
    settle();
    write_reg(CFG_FCNT, 7'd0);
    send_word(MODE_ACC, 9, 100, 0, 1);
    send_word(MODE_LOAD, 9, 0, 0, 7);

    // The widest count the register holds, past the number of lanes there are.
    settle();
    write_reg(CFG_FCNT, 7'd127);
    send_word(MODE_READ, 1023, 0, 63, 0);

    // Random phases, each under its own register setting. The aggregation mode
    // alternates, and the last phase runs with no idle gaps at all.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       lanes = MAX_FEATURES;
        1:       lanes = 1;
        2:       lanes = 127;
        default: lanes = $urandom_range(1, MAX_FEATURES);
      endcase
      cur_by_row = ((phase % 2) == 1);
      write_reg(CFG_AGG, CFG_DATA_W'(cur_by_row));
      write_reg(CFG_FCNT, CFG_DATA_W'(lanes));
      steady = (phase == PHASES - 1);
      repeat (RANDOM_WORDS / PHASES) send_random(lanes);
      if (phase == 0) steady = 1'b0;
    end

    // Any result word that is missing keeps this waiting until the watchdog fires;
    // any extra one is counted by the checker during the drain.
    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
